>>> hw/rtl/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> hw/rtl/pbts_pkg.sv
// Types and constants for the priority bitmap task scheduler.
`default_nettype none
package pbts_pkg;

    localparam int KIND_W = 3;
    localparam int TICK_W = 32;
    localparam int MASK_W = 32;
    localparam int PRIO_W = 5;
    localparam int LOCK_W = 8;

    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_DELAY  = 3'd2,
        KIND_LOCK   = 3'd3,
        KIND_UNLOCK = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic wr_en;
    } ram_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/pbts_delay_ram.sv
// Delay counter memory with per-entry valid bits; invalid entries read as zero.
`default_nettype none
module pbts_delay_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pbts_pkg::ram_cmd_t       cmd,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    import pbts_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.clr)
        begin
            vld_next = '0;
        end
        else if (cmd.wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

>>> hw/rtl/priority_bitmap_task_scheduler.sv
// Top level: event sequencer, slot walk and scheduling decision.
// The result strobe (done) is registered from the DONE state, which follows the walk over S = min(NUM_SLOTS, 32) slots.
// The block takes no new item until the last one is done; busy covers the slot walk,
// which visits one slot a cycle through the delay memory and one decrementer.
// done is high for one cycle and cannot be held off; the next item may start in that cycle.
// Reset: rst_n, async active low; clears ready bits, delay counters, lock count, mask.
`default_nettype none
`include "assert_macros.svh"
module priority_bitmap_task_scheduler #(
    parameter int NUM_SLOTS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [pbts_pkg::KIND_W-1:0]  kind,
    input  wire logic [pbts_pkg::TICK_W-1:0]  delay_ticks,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [pbts_pkg::MASK_W-1:0]  cfg_data,
    output logic                              done,
    output logic                              switch_now,
    output logic      [pbts_pkg::PRIO_W-1:0]  next_prio,
    output logic                              none_ready,
    output logic      [pbts_pkg::LOCK_W-1:0]  lock_count
);
    import pbts_pkg::*;

    localparam int USABLE = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
    localparam int IDX_W  = $clog2(USABLE);
    localparam int CNT_W  = $clog2(USABLE + 1);

    state_t state_reg, state_next;

    logic [MASK_W-1:0] mask_reg;
    logic [USABLE-1:0] ready_reg, ready_next;
    logic [LOCK_W-1:0] lock_reg, lock_next;
    logic [PRIO_W-1:0] running_reg, running_next;
    logic [KIND_W-1:0] op_reg, op_next;
    logic              sched_reg, sched_next;
    logic              force_reg, force_next;
    logic [CNT_W-1:0]  walk_cnt_reg, walk_cnt_next;
    logic              proc_vld_reg, proc_vld_next;
    logic [IDX_W-1:0]  proc_idx_reg, proc_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  win_reg, win_next;
    logic              done_reg, done_next;
    logic              switch_reg, switch_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic              none_reg, none_next;

    logic              accept;
    logic              walk_last;
    ram_cmd_t          ram_cmd;
    logic [IDX_W-1:0]  wr_addr;
    logic [TICK_W-1:0] wr_data;
    logic [TICK_W-1:0] rd_data;
    logic [TICK_W-1:0] dec_val;
    logic              tick_hit;
    logic              slot_rdy;

    assign accept    = start && (state_reg == ST_IDLE);
    assign walk_last = (walk_cnt_reg == CNT_W'(USABLE));
    assign dec_val   = rd_data - TICK_W'(1);
    // present slot under tick with a counter already at zero becomes ready
    assign tick_hit  = proc_vld_reg && (kind_t'(op_reg) == KIND_TICK)
                       && mask_reg[proc_idx_reg] && (rd_data == '0);
    assign slot_rdy  = proc_vld_reg && (ready_reg[proc_idx_reg] || tick_hit);

    pbts_delay_ram #(
        .DEPTH (USABLE),
        .WIDTH (TICK_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ram_cmd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (walk_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs: handshake and memory control
    always_comb
    begin
        busy            = 1'b1;
        ram_cmd.clr     = 1'b0;
        ram_cmd.wr_en   = 1'b0;
        wr_addr         = proc_idx_reg;
        wr_data         = dec_val;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start && (kind_t'(kind) == KIND_START))
                begin
                    ram_cmd.clr = 1'b1;
                end
                if (start && (kind_t'(kind) == KIND_DELAY))
                begin
                    ram_cmd.wr_en = 1'b1;
                    wr_addr       = running_reg[IDX_W-1:0];
                    wr_data       = delay_ticks;
                end
            end
            ST_WALK:
            begin
                ram_cmd.wr_en = proc_vld_reg && (kind_t'(op_reg) == KIND_TICK)
                                && mask_reg[proc_idx_reg] && (rd_data != '0);
            end
            ST_DONE:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ready_next    = ready_reg;
        lock_next     = lock_reg;
        running_next  = running_reg;
        op_next       = op_reg;
        sched_next    = sched_reg;
        force_next    = force_reg;
        walk_cnt_next = walk_cnt_reg;
        proc_vld_next = 1'b0;
        proc_idx_next = walk_cnt_reg[IDX_W-1:0];
        found_next    = found_reg;
        win_next      = win_reg;
        done_next     = 1'b0;
        switch_next   = switch_reg;
        prio_next     = prio_reg;
        none_next     = none_reg;

        if (accept)
        begin
            op_next       = kind;
            sched_next    = 1'b0;
            force_next    = 1'b0;
            walk_cnt_next = '0;
            found_next    = 1'b0;
            win_next      = '0;
            case (kind_t'(kind))
                KIND_START:
                begin
                    ready_next = mask_reg[USABLE-1:0];
                    force_next = 1'b1;
                end
                KIND_TICK:
                begin
                    sched_next = 1'b1;
                end
                KIND_DELAY:
                begin
                    ready_next[running_reg[IDX_W-1:0]] = 1'b0;
                    sched_next = 1'b1;
                end
                KIND_LOCK:
                begin
                    if (lock_reg != LOCK_MAX)
                    begin
                        lock_next = lock_reg + LOCK_W'(1);
                    end
                end
                KIND_UNLOCK:
                begin
                    if (lock_reg != '0)
                    begin
                        lock_next  = lock_reg - LOCK_W'(1);
                        sched_next = (lock_reg == LOCK_W'(1));
                    end
                end
                default:
                begin
                    sched_next = 1'b0;
                end
            endcase
        end

        if (state_reg == ST_WALK)
        begin
            if (!walk_last)
            begin
                walk_cnt_next = walk_cnt_reg + CNT_W'(1);
                proc_vld_next = 1'b1;
            end
            if (tick_hit)
            begin
                ready_next[proc_idx_reg] = 1'b1;
            end
            // lowest index wins: first ready slot seen in the walk
            if (slot_rdy && !found_reg)
            begin
                found_next = 1'b1;
                win_next   = proc_idx_reg;
            end
        end

        if (state_reg == ST_DONE)
        begin
            done_next   = 1'b1;
            switch_next = 1'b0;
            prio_next   = found_reg ? PRIO_W'(win_reg) : '0;
            none_next   = !found_reg;
            if (found_reg && force_reg)
            begin
                running_next = PRIO_W'(win_reg);
                switch_next  = 1'b1;
            end
            else if (found_reg && sched_reg && (lock_reg == '0)
                     && (PRIO_W'(win_reg) != running_reg))
            begin
                running_next = PRIO_W'(win_reg);
                switch_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            ready_reg    <= '0;
            lock_reg     <= '0;
            running_reg  <= '0;
            walk_cnt_reg <= '0;
            proc_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            lock_reg     <= lock_next;
            running_reg  <= running_next;
            walk_cnt_reg <= walk_cnt_next;
            proc_vld_reg <= proc_vld_next;
            done_reg     <= done_next;
            if (cfg_valid)
            begin
                mask_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        sched_reg    <= sched_next;
        force_reg    <= force_next;
        proc_idx_reg <= proc_idx_next;
        found_reg    <= found_next;
        win_reg      <= win_next;
        switch_reg   <= switch_next;
        prio_reg     <= prio_next;
        none_reg     <= none_next;
    end

    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign switch_now = switch_reg;
    assign next_prio  = prio_reg;
    assign none_ready = none_reg;
    assign lock_count = lock_reg;

    `ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_done_after, clk, rst_n, state_reg == ST_DONE, done_reg)
    `ASSERT_NEXT(a_walk_end, clk, rst_n, (state_reg == ST_WALK) && walk_last,
                 state_reg == ST_DONE)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `ASSERT_IMPL(a_switch_ready, clk, rst_n, done_reg && switch_reg, !none_reg)

endmodule
`default_nettype wire

>>> verif/tb_priority_bitmap_task_scheduler.sv
// Self-checking testbench for the priority bitmap task scheduler.
`timescale 1ns / 1ps
module tb_priority_bitmap_task_scheduler;
    import pbts_pkg::*;

    localparam int SLOTS        = 32;
    localparam int USABLE_SLOTS = (SLOTS < 32) ? SLOTS : 32;
    localparam logic [MASK_W-1:0] USABLE_MASK =
        (USABLE_SLOTS >= 32) ? '1 : ((32'd1 << USABLE_SLOTS) - 32'd1);
    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = USABLE_SLOTS + 8;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TICK_W-1:0] ticks;
    } sched_event_t;

    typedef struct packed {
        logic              sw;
        logic [PRIO_W-1:0] prio;
        logic              none;
        logic [LOCK_W-1:0] lock;
    } sched_status_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] kind = '0;
    logic [TICK_W-1:0] delay_ticks = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MASK_W-1:0] cfg_data = '0;
    logic              done;
    logic              switch_now;
    logic [PRIO_W-1:0] next_prio;
    logic              none_ready;
    logic [LOCK_W-1:0] lock_count;

    priority_bitmap_task_scheduler #(.NUM_SLOTS(SLOTS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .delay_ticks (delay_ticks),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .switch_now  (switch_now),
        .next_prio   (next_prio),
        .none_ready  (none_ready),
        .lock_count  (lock_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scheduler state as predicted by the testbench
    logic [MASK_W-1:0] sched_mask = '0;
    logic [MASK_W-1:0] sched_ready = '0;
    logic [TICK_W-1:0] sched_delay [SLOTS];
    logic [LOCK_W-1:0] sched_lock = '0;
    logic [PRIO_W-1:0] sched_running = '0;

    sched_event_t  pending_events [$];
    sched_status_t expected_status [$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   sender_gap_max = 14;
    int   gap_left = 0;
    logic gap_after_idle = 1'b0;
    logic presenting = 1'b0;
    logic item_taken = 1'b0;
    logic cfg_taken = 1'b0;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            sched_delay[i] = '0;
    end

    function automatic logic lowest_ready(output logic [PRIO_W-1:0] slot);
        logic [MASK_W-1:0] r;
        r = sched_ready & USABLE_MASK;
        slot = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
            if (r[i])
                slot = PRIO_W'(i);
        return r != '0;
    endfunction

    // normal scheduling point: switch only when unlocked and the winner moved
    function automatic logic dispatch();
        logic [PRIO_W-1:0] w;
        if (sched_lock != '0)
            return 1'b0;
        if (!lowest_ready(w))
            return 1'b0;
        if (w != sched_running)
        begin
            sched_running = w;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sched_status_t schedule_event(input logic [KIND_W-1:0] k,
                                                     input logic [TICK_W-1:0] ticks);
        sched_status_t     s;
        logic              sw;
        logic              any;
        logic [PRIO_W-1:0] w;
        sw = 1'b0;
        case (k)
            KIND_START:
            begin
                sched_ready = sched_mask & USABLE_MASK;
                for (int i = 0; i < SLOTS; i++)
                    sched_delay[i] = '0;
                // start launches the first task even while locked
                if (lowest_ready(w))
                begin
                    sched_running = w;
                    sw = 1'b1;
                end
            end
            KIND_TICK:
            begin
                for (int i = 0; i < USABLE_SLOTS; i++)
                    if (sched_mask[i])
                    begin
                        if (sched_delay[i] != '0)
                            sched_delay[i] = sched_delay[i] - TICK_W'(1);
                        else
                            sched_ready[i] = 1'b1;
                    end
                sw = dispatch();
            end
            KIND_DELAY:
            begin
                if (int'(sched_running) < SLOTS)
                    sched_delay[sched_running] = ticks;
                sched_ready[sched_running] = 1'b0;
                sw = dispatch();
            end
            KIND_LOCK:
            begin
                if (sched_lock != LOCK_MAX)
                    sched_lock = sched_lock + LOCK_W'(1);
            end
            KIND_UNLOCK:
            begin
                if (sched_lock != '0)
                begin
                    sched_lock = sched_lock - LOCK_W'(1);
                    if (sched_lock == '0)
                        sw = dispatch();
                end
            end
            default:
            begin
            end
        endcase
        any = lowest_ready(w);
        s.sw = sw;
        s.prio = w;
        s.none = !any;
        s.lock = sched_lock;
        return s;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch on %s: got %0h, expected %0h (cycle %0d)",
                 field, got, want, cycle_count);
    endtask

    task automatic push_item(input logic [KIND_W-1:0] k, input logic [TICK_W-1:0] t);
        sched_event_t e;
        e.kind = k;
        e.ticks = t;
        pending_events.push_back(e);
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || presenting || expected_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_task_mask(input logic [MASK_W-1:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        cfg_taken = 1'b0;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // driver: presents queued items, inputs change on the falling edge
    always @(negedge clk)
    begin
        sched_event_t cur;
        if (rst_n)
        begin
            if (item_taken)
            begin
                item_taken = 1'b0;
                presenting = 1'b0;
                gap_left = $urandom_range(sender_gap_max, 0);
                gap_after_idle = 1'($urandom_range(1, 0));
            end
            if (!presenting)
            begin
                if (gap_left != 0)
                begin
                    // some gaps count only once the block has gone idle
                    if (!gap_after_idle || !busy)
                        gap_left--;
                end
                else if (pending_events.size() != 0)
                begin
                    cur = pending_events.pop_front();
                    kind <= cur.kind;
                    delay_ticks <= cur.ticks;
                    presenting = 1'b1;
                end
            end
            if (!presenting)
            begin
                kind <= KIND_W'($urandom);
                delay_ticks <= $urandom;
            end
            start <= presenting;
        end
    end

    // monitor: takes items and results at the rising edge
    always @(posedge clk)
    begin
        sched_status_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (expected_status.size() == 0)
                    report_mismatch("unexpected result", {31'd0, done}, 32'd0);
                else
                begin
                    want = expected_status.pop_front();
                    if (switch_now !== want.sw)
                        report_mismatch("switch_now", 32'(switch_now), 32'(want.sw));
                    if (next_prio !== want.prio)
                        report_mismatch("next_prio", 32'(next_prio), 32'(want.prio));
                    if (none_ready !== want.none)
                        report_mismatch("none_ready", 32'(none_ready), 32'(want.none));
                    if (lock_count !== want.lock)
                        report_mismatch("lock_count", 32'(lock_count), 32'(want.lock));
                end
            end
            if (start && !busy)
            begin
                expected_status.push_back(schedule_event(kind, delay_ticks));
                item_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                sched_mask = cfg_data;
                cfg_taken = 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int                unsigned roll;
        int                counted;
        logic [MASK_W-1:0] mask_val;
        logic [TICK_W-1:0] ticks_val;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // no task present: nothing can become ready
        sender_gap_max = 14;
        write_task_mask('0);
        push_item(KIND_START, '0);
        push_item(KIND_TICK, '1);
        push_item(KIND_DELAY, 32'd7);
        push_item(KIND_UNLOCK, '0);
        push_item(KIND_LOCK, '0);
        push_item(KIND_UNLOCK, '0);
        push_item(KIND_FIRST_UNUSED, '1);
        push_item(KIND_FIRST_UNUSED + 3'd1, '0);
        push_item(KIND_LAST_UNUSED, 32'hA5A5_5A5A);
        wait_idle();

        // extreme slots only: locking, delay extremes, start while locked
        write_task_mask(32'h8000_0001);
        push_item(KIND_START, '0);
        push_item(KIND_DELAY, '1);
        push_item(KIND_TICK, '0);
        push_item(KIND_LOCK, '0);
        push_item(KIND_DELAY, '0);
        push_item(KIND_TICK, '0);
        push_item(KIND_UNLOCK, '0);
        push_item(KIND_LOCK, '0);
        push_item(KIND_START, '0);
        push_item(KIND_UNLOCK, '0);
        push_item(KIND_DELAY, 32'd2);
        push_item(KIND_TICK, '0);
        push_item(KIND_TICK, '0);
        push_item(KIND_TICK, '0);
        wait_idle();

        // lock count saturation and full unwind
        sender_gap_max = 0;
        write_task_mask($urandom | 32'h0000_0100);
        push_item(KIND_START, $urandom);
        repeat (LOCK_MAX + 3) push_item(KIND_LOCK, $urandom);
        repeat (3) push_item(KIND_TICK, $urandom);
        push_item(KIND_DELAY, 32'd1);
        repeat (LOCK_MAX + 1) push_item(KIND_UNLOCK, $urandom);
        push_item(KIND_TICK, $urandom);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 6)
                0: mask_val = $urandom;
                1: mask_val = '1;
                2: mask_val = 32'h0000_0001;
                3: mask_val = 32'h8000_0000;
                4: mask_val = $urandom & $urandom & $urandom;
                default: mask_val = '0;
            endcase
            sender_gap_max = (p % 3 == 2) ? 0 : 14;
            write_task_mask(mask_val);
            // a phase without start keeps ready bits from the old mask
            if (p == 0 || $urandom_range(1, 0) == 1)
                push_item(KIND_START, $urandom);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99, 0);
                counted++;
                if (roll < 46)
                    push_item(KIND_TICK, $urandom);
                else if (roll < 68)
                begin
                    roll = $urandom_range(9, 0);
                    if (roll < 6)
                        ticks_val = $urandom_range(4, 0);
                    else if (roll < 8)
                        ticks_val = $urandom_range(30, 0);
                    else
                        ticks_val = $urandom;
                    push_item(KIND_DELAY, ticks_val);
                end
                else if (roll < 78)
                    push_item(KIND_LOCK, $urandom);
                else if (roll < 90)
                    push_item(KIND_UNLOCK, $urandom);
                else if (roll < 95)
                    push_item(KIND_START, $urandom);
                else
                begin
                    push_item(KIND_W'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED)),
                              $urandom);
                    counted--;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> priority_bitmap_task_scheduler.f
+incdir+hw/rtl
hw/rtl/pbts_pkg.sv
hw/rtl/pbts_delay_ram.sv
hw/rtl/priority_bitmap_task_scheduler.sv
verif/tb_priority_bitmap_task_scheduler.sv
